// ===== design/lom_pkg.sv =====
`timescale 1ns / 1ps
package lom_pkg;

    localparam int NumStocksDef = 5;
    localparam int BookDepthDef = 256;
    localparam int MaxOrdersDef = 4096;

    localparam logic [1:0] OP_BUY    = 2'd0;
    localparam logic [1:0] OP_SELL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_SETQ   = 3'd2;
    localparam logic [2:0] CMD_INSERT = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] order_number;
        logic [2:0]  stock;
        logic [15:0] quantity;
        logic [19:0] price;
    } t_in;

    typedef struct packed {
        logic [15:0] remaining_quantity;
        logic [19:0] best_profit;
        logic        book_full;
        logic        cancel_done;
    } t_out;

    typedef struct packed {
        logic [19:0] price;
        logic [15:0] qty;
        logic [11:0] id;
    } t_entry;

    typedef struct packed {
        logic [2:0] cmd;
        logic       side;
        t_entry     ent;
    } t_cell_ctl;

    // entry a has lower priority than entry b in a book of the given side
    function automatic logic sits_below(logic side, logic [19:0] pa, logic [11:0] ia,
                                        logic [19:0] pb, logic [11:0] ib);
        logic r;
        if (pa == pb) begin
            r = ia > ib;
        end else begin
            r = side ? (pa > pb) : (pa < pb);
        end
        return r;
    endfunction

endpackage

// ===== design/limit_order_matcher.sv =====
`timescale 1ns / 1ps
// limit order matcher: price-priority books, ties to the lower order number, one item in, one result out.
// input channel i_in_valid/o_in_stall carries buy, sell and cancel items;
// output channel o_out_valid/i_out_stall carries one result item per input item.
// each book is a row of BOOK_DEPTH slots; slot 0 holds the best entry and every
// slot shifts with its neighbors, so a fill, an insert or a removal updates all slots together.
// a new order passes lookup, match (repeated while fills against the opposite book
// go on), place and out; a cancel passes lookup, find, del and out; invalid or unused
// codes go from lookup straight to out. one item is in work at a time, the next is
// accepted in the cycle after the result is loaded.
// after reset the order record memory is cleared one entry a cycle, all MAX_ORDERS
// entries, while o_in_stall stays high.
// the result sits in an output register; an item may be accepted while it waits,
// and the block holds its next result while i_out_stall is high.
module limit_order_matcher #(
    parameter int NUM_STOCKS = lom_pkg::NumStocksDef,
    parameter int BOOK_DEPTH = lom_pkg::BookDepthDef,
    parameter int MAX_ORDERS = lom_pkg::MaxOrdersDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lom_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lom_pkg::t_out o_out_data
);
    localparam int NUM_BOOKS = NUM_STOCKS * 2;
    localparam int SW = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;
    localparam int BW = $clog2(NUM_BOOKS);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int PW = $clog2(BOOK_DEPTH);
    localparam int AW = $clog2(MAX_ORDERS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_FIND   = 3'd5;
    localparam logic [2:0] S_DEL    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    typedef struct packed {
        logic          active;
        logic          side;
        logic [SW-1:0] stock;
    } t_rec;

    logic [2:0]     r_state;
    logic [1:0]     r_op;
    logic [11:0]    r_id;
    logic [2:0]     r_st;
    logic [15:0]    r_q;
    logic [19:0]    r_px;
    logic [SW-1:0]  r_s;
    logic [BW-1:0]  r_book;
    logic [PW-1:0]  r_pos;
    logic           r_found;
    logic [15:0]    r_rem;
    logic           r_full;
    logic           r_done;
    logic [AW-1:0]  r_clr;
    logic [CW-1:0]  r_cnt [NUM_BOOKS];
    logic [19:0]    r_low [NUM_STOCKS];
    logic [19:0]    r_rise [NUM_STOCKS];
    logic           r_ovalid;
    lom_pkg::t_out  r_odata;

    t_rec           r_rec_mem [MAX_ORDERS];
    t_rec           r_rd;
    logic           w_we;
    logic [AW-1:0]  w_wa;
    t_rec           w_wd;
    logic [31:0]    w_in_id32;
    logic [31:0]    w_id32;

    lom_pkg::t_cell_ctl w_ctl;
    lom_pkg::t_entry    w_ent   [BOOK_DEPTH];
    logic               w_below [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] w_match;
    logic [PW-1:0]      w_pos;
    logic [CW-1:0]      w_cnt;

    logic           w_accept;
    logic           w_st_ok;
    logic [3:0]     w_s_full;
    logic [SW-1:0]  w_s;
    logic           w_in_range;
    lom_pkg::t_entry w_head;
    logic           w_cross;
    logic [19:0]    w_lo0;
    logic [19:0]    w_diff;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assign w_in_id32 = 32'(i_in_data.order_number);
    assign w_id32    = 32'(r_id);
    assign w_in_range = w_id32 < MAX_ORDERS;
    assign w_st_ok  = (r_st >= 3'd1) && (32'(r_st) <= NUM_STOCKS);
    assign w_s_full = 4'({1'b0, r_st} - 4'd1);
    assign w_s      = w_s_full[SW-1:0];
    assign w_cnt    = r_cnt[r_book];
    assign w_head   = w_ent[0];
    assign w_cross  = r_op[0] ? (w_head.price >= r_px) : (w_head.price <= r_px);
    assign w_lo0    = (r_low[r_s] == 20'd0) ? w_head.price : r_low[r_s];
    assign w_diff   = w_head.price - w_lo0;

    // order record memory, registered read at the incoming id
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_rec_mem[w_wa] <= w_wd;
        end
        r_rd <= r_rec_mem[w_in_id32[AW-1:0]];
    end

    // record writes and cell commands
    always_comb begin
        w_we  = 1'b0;
        w_wa  = w_id32[AW-1:0];
        w_wd  = '0;
        w_ctl.cmd = lom_pkg::CMD_NONE;
        w_ctl.side = r_op[0];
        w_ctl.ent.price = r_px;
        w_ctl.ent.qty   = r_q;
        w_ctl.ent.id    = r_id;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
            end
            S_MATCH: begin
                if (r_q != 16'd0 && w_cnt != '0 && w_cross) begin
                    if (w_head.qty > r_q) begin
                        w_ctl.cmd = lom_pkg::CMD_SETQ;
                        w_ctl.ent.qty = w_head.qty - r_q;
                    end else begin
                        w_ctl.cmd = lom_pkg::CMD_POP;
                        w_we = 1'b1;
                        w_wa = AW'(32'(w_head.id));
                    end
                end
            end
            S_PLACE: begin
                if (r_q != 16'd0 && 32'(w_cnt) < BOOK_DEPTH) begin
                    w_ctl.cmd = lom_pkg::CMD_INSERT;
                    w_we = 1'b1;
                    w_wd.active = 1'b1;
                    w_wd.side = r_op[0];
                    w_wd.stock = r_s;
                end
            end
            S_DEL: begin
                if (r_found) begin
                    w_ctl.cmd = lom_pkg::CMD_REMOVE;
                    w_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // row of book slots
    for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
        lom_cell #(
            .IDX(k), .NUM_BOOKS(NUM_BOOKS), .BOOK_DEPTH(BOOK_DEPTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_book       (r_book),
            .i_ctl        (w_ctl),
            .i_count      (w_cnt),
            .i_pos        (r_pos),
            .i_left       ((k == 0) ? lom_pkg::t_entry'('0) : w_ent[(k == 0) ? 0 : k - 1]),
            .i_left_below ((k == 0) ? 1'b0 : w_below[(k == 0) ? 0 : k - 1]),
            .i_right      ((k == BOOK_DEPTH - 1) ? lom_pkg::t_entry'('0)
                           : w_ent[(k == BOOK_DEPTH - 1) ? k : k + 1]),
            .o_entry      (w_ent[k]),
            .o_below      (w_below[k]),
            .o_match      (w_match[k])
        );
    end

    // slot number of the matching entry
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            if (w_match[k]) begin
                w_pos = w_pos | PW'(k);
            end
        end
    end

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int b = 0; b < NUM_BOOKS; b++) begin
                r_cnt[b] <= '0;
            end
            for (int s = 0; s < NUM_STOCKS; s++) begin
                r_low[s]  <= '0;
                r_rise[s] <= '0;
            end
        end else begin
            // result taken and no new one loaded this cycle
            if (r_ovalid && !i_out_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_ORDERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_in_data.operation;
                        r_id  <= i_in_data.order_number;
                        r_st  <= i_in_data.stock;
                        r_q   <= i_in_data.quantity;
                        r_px  <= i_in_data.price;
                        r_rem <= '0;
                        r_full <= 1'b0;
                        r_done <= 1'b0;
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_s <= w_s;
                    r_state <= S_OUT;
                    if (r_op == lom_pkg::OP_BUY || r_op == lom_pkg::OP_SELL) begin
                        if (w_st_ok && r_q != 16'd0 && r_px != 20'd0 && w_in_range
                            && !r_rd.active) begin
                            r_book  <= BW'({w_s, ~r_op[0]});
                            r_state <= S_MATCH;
                        end
                    end else if (r_op == lom_pkg::OP_CANCEL) begin
                        if (w_in_range && r_rd.active) begin
                            r_book  <= BW'({r_rd.stock, r_rd.side});
                            r_state <= S_FIND;
                        end
                    end
                end
                S_MATCH: begin
                    if (r_q != 16'd0 && w_cnt != '0 && w_cross) begin
                        if (w_head.price > w_lo0 && w_diff > r_rise[r_s]) begin
                            r_rise[r_s] <= w_diff;
                        end
                        r_low[r_s] <= (w_head.price < w_lo0) ? w_head.price : w_lo0;
                        if (w_head.qty > r_q) begin
                            r_q <= '0;
                        end else begin
                            r_q <= r_q - w_head.qty;
                            r_cnt[r_book] <= w_cnt - 1'b1;
                        end
                    end else begin
                        r_book  <= BW'({r_s, r_op[0]});
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (r_q != 16'd0) begin
                        if (32'(w_cnt) < BOOK_DEPTH) begin
                            r_cnt[r_book] <= w_cnt + 1'b1;
                            r_rem <= r_q;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_FIND: begin
                    r_pos   <= w_pos;
                    r_found <= |w_match;
                    r_state <= S_DEL;
                end
                S_DEL: begin
                    if (r_found) begin
                        r_cnt[r_book] <= w_cnt - 1'b1;
                        r_done <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_odata.remaining_quantity <= r_rem;
                        r_odata.best_profit <= w_st_ok ? r_rise[w_s] : 20'd0;
                        r_odata.book_full   <= r_full;
                        r_odata.cancel_done <= r_done;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/lom_cell.sv =====
`timescale 1ns / 1ps
module lom_cell #(
    parameter int IDX       = 0,
    parameter int NUM_BOOKS = 10,
    parameter int BOOK_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic [$clog2(NUM_BOOKS)-1:0]       i_book,
    input  lom_pkg::t_cell_ctl                 i_ctl,
    input  logic [$clog2(BOOK_DEPTH+1)-1:0]    i_count,
    input  logic [$clog2(BOOK_DEPTH)-1:0]      i_pos,
    input  lom_pkg::t_entry                    i_left,
    input  logic                               i_left_below,
    input  lom_pkg::t_entry                    i_right,
    output lom_pkg::t_entry                    o_entry,
    output logic                               o_below,
    output logic                               o_match
);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int PW = $clog2(BOOK_DEPTH);

    lom_pkg::t_entry r_mem [NUM_BOOKS];
    logic            w_valid;

    // entry of the selected book held in this slot
    assign o_entry = r_mem[i_book];
    assign w_valid = CW'(IDX) < i_count;
    assign o_below = !w_valid || lom_pkg::sits_below(i_ctl.side, o_entry.price, o_entry.id,
                                                     i_ctl.ent.price, i_ctl.ent.id);
    assign o_match = w_valid && (o_entry.id == i_ctl.ent.id);

    // slot update, shifting with neighbors
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            lom_pkg::CMD_POP: begin
                r_mem[i_book] <= i_right;
            end
            lom_pkg::CMD_SETQ: begin
                if (IDX == 0) begin
                    r_mem[i_book].qty <= i_ctl.ent.qty;
                end
            end
            lom_pkg::CMD_INSERT: begin
                if (o_below) begin
                    if (i_left_below) begin
                        r_mem[i_book] <= i_left;
                    end else begin
                        r_mem[i_book] <= i_ctl.ent;
                    end
                end
            end
            lom_pkg::CMD_REMOVE: begin
                if (PW'(IDX) >= i_pos) begin
                    r_mem[i_book] <= i_right;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
